@@ src/bgns_pkg.sv @@
// Shared types, constants and codes for the binary grid smoothing unit.
// Used by bgns_count and the top module; depends on nothing.
`default_nettype none

package bgns_pkg;

  localparam int MAX_WIDTH       = 64;
  localparam int MAX_HEIGHT      = 64;
  localparam int MIN_SMOOTH_SIZE = 3;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  // Wide enough for the 7-bit size registers and for any dimension plus one.
  localparam int DIM_W   = ($clog2(DIM_MAX + 2) > 7) ? $clog2(DIM_MAX + 2) : 7;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SMOOTH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_COUNT  = 2'd3;

  typedef logic [MAX_WIDTH-1:0] row_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
    logic       cell_value;
  } cmd_t;

  typedef struct packed {
    logic       read_value;
    logic       out_of_range;
    logic [3:0] passes_done;
  } result_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_LOAD_UP,
    S_LOAD_MID,
    S_LOAD_DN,
    S_COLUMN,
    S_WRITE
  } state_t;

endpackage

`default_nettype wire

@@ src/bgns_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
`default_nettype none

module bgns_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/bgns_count.sv @@
// Shared neighbour unit: counts the wall cells around one column of a
// three-row window and applies the threshold rule. Depends on bgns_pkg.
`default_nettype none

module bgns_count
  import bgns_pkg::*;
(
  input  wire logic [COL_W-1:0] col,
  input  wire row_t             up,
  input  wire row_t             mid,
  input  wire row_t             dn,
  input  wire logic [3:0]       threshold,
  output logic                  new_bit
);

  logic [COL_W-1:0] col_l;
  logic [COL_W-1:0] col_r;
  logic [3:0]       walls;

  assign col_l = col - COL_W'(1);
  assign col_r = col + COL_W'(1);

  assign walls = 4'(up[col_l]) + 4'(up[col]) + 4'(up[col_r])
               + 4'(mid[col_l]) + 4'(mid[col_r])
               + 4'(dn[col_l]) + 4'(dn[col]) + 4'(dn[col_r]);

  // Above the threshold: wall, below: floor, equal: hold.
  always_comb begin
    priority if (walls > threshold) begin
      new_bit = 1'b1;
    end else if (walls < threshold) begin
      new_bit = 1'b0;
    end else begin
      new_bit = mid[col];
    end
  end

endmodule

`default_nettype wire

@@ src/binary_grid_neighbour_smoothing_unit.sv @@
// Binary grid smoothing unit: one-bit wall/floor grid with write, read and
// threshold smoothing commands. Depends on bgns_pkg, bgns_ram, bgns_count.
`default_nettype none

// Usage
//   Command channel: a word on cmd is taken at a rising edge where start is
//   high and busy is low. Opcodes: write cell, smooth, read cell.
//   Result channel: one word per command on result, shown for exactly one
//   cycle while done is high. The receiver cannot stall; there is no hold.
//   Configuration: cfg_we/cfg_index/cfg_data write grid_width, grid_height,
//   wall_limit and pass_count; write only while idle.
// Command flow
//   Out-of-range access, unused opcode, or a smooth that runs no pass:
//   done rises in the cycle after accept and busy stays low throughout.
//   In-range read or write: the row is read from the grid RAM at accept; in
//   the access state, with busy high, a read takes its cell and a write puts
//   the row back with the cell replaced. done is registered from there.
//   Smooth: the grid is held as rows in one RAM; each pass streams rows
//   through a three-row window, and one shared neighbour unit evaluates one
//   cell a cycle in the column state, between row loads and row writes.
// Reset
//   rst (synchronous) restores the register defaults and starts a clearing
//   sweep that writes every RAM row (MAX_HEIGHT, 64) to wall, one row a
//   cycle, with busy high. Configuration writes are taken meanwhile.

module binary_grid_neighbour_smoothing_unit
  import bgns_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire cmd_t                 cmd,
  output logic                      done,
  output result_t                   result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [6:0] grid_width;
  logic [6:0] grid_height;
  logic [3:0] wall_limit;
  logic [3:0] pass_count;

  // Sequencer and counters.
  state_t           state;
  state_t           state_next;
  logic [DIM_W-1:0] row_cnt;
  logic [DIM_W-1:0] col_cnt;
  logic [3:0]       pass_idx;

  // Latched command, row window and work row.
  cmd_t    cur;
  row_t    up;
  row_t    mid;
  row_t    dn;
  row_t    newrow;
  result_t result_next;
  logic    done_next;

  // RAM port signals.
  logic             ram_we;
  logic [ROW_W-1:0] ram_waddr;
  row_t             ram_wdata;
  logic [ROW_W-1:0] ram_raddr;
  row_t             ram_rdata;
  row_t             mod_row;

  logic [DIM_W-1:0] used_w;
  logic [DIM_W-1:0] used_h;
  logic [DIM_W-1:0] in_col;
  logic [DIM_W-1:0] in_row;
  logic [COL_W-1:0] cur_col_idx;
  logic             accept;
  logic             in_range;
  logic             is_access;
  logic             smooth_ok;
  logic             last_col;
  logic             last_row;
  logic             last_pass;
  logic             new_bit;

  // Sizes above the grid's capacity act as the capacity.
  assign used_w = (DIM_W'(grid_width) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                           : DIM_W'(grid_width);
  assign used_h = (DIM_W'(grid_height) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                             : DIM_W'(grid_height);

  assign in_col    = DIM_W'(cmd.cell_col);
  assign in_row    = DIM_W'(cmd.cell_row);
  assign accept    = start && !busy;
  assign in_range  = (in_col < used_w) && (in_row < used_h);
  assign is_access = (cmd.opcode == OP_READ) || (cmd.opcode == OP_WRITE);
  assign smooth_ok = (used_w >= DIM_W'(MIN_SMOOTH_SIZE))
                  && (used_h >= DIM_W'(MIN_SMOOTH_SIZE))
                  && (pass_count != 4'd0);

  assign cur_col_idx = COL_W'(DIM_W'(cur.cell_col));
  assign last_col    = (DIM_W'(col_cnt + DIM_W'(2)) == used_w);
  assign last_row    = (DIM_W'(row_cnt + DIM_W'(2)) == used_h);
  assign last_pass   = ((pass_idx + 4'd1) == pass_count);

  assign busy = (state != S_IDLE);

  bgns_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bgns_count u_count (
    .col       (COL_W'(col_cnt)),
    .up        (up),
    .mid       (mid),
    .dn        (dn),
    .threshold (wall_limit),
    .new_bit   (new_bit)
  );

  // Row with the addressed cell replaced, for a cell write.
  always_comb begin
    mod_row              = ram_rdata;
    mod_row[cur_col_idx] = cur.cell_value;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (row_cnt == DIM_W'(MAX_HEIGHT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (is_access && in_range) begin
            state_next = S_ACCESS;
          end else if ((cmd.opcode == OP_SMOOTH) && smooth_ok) begin
            state_next = S_LOAD_UP;
          end
        end
      end
      S_ACCESS:   state_next = S_IDLE;
      S_LOAD_UP:  state_next = S_LOAD_MID;
      S_LOAD_MID: state_next = S_LOAD_DN;
      S_LOAD_DN:  state_next = S_COLUMN;
      S_COLUMN: begin
        if (last_col) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!last_row) begin
          state_next = S_LOAD_DN;
        end else if (!last_pass) begin
          state_next = S_LOAD_UP;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // RAM control and result.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = ROW_W'(row_cnt);
    ram_wdata   = newrow;
    ram_raddr   = '0;
    done_next   = 1'b0;
    result_next = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
      end
      S_IDLE: begin
        if (accept) begin
          if (cmd.opcode != OP_SMOOTH) begin
            ram_raddr = ROW_W'(cmd.cell_row);
          end
          // Everything that needs no grid access answers at once.
          if (!((is_access && in_range) || ((cmd.opcode == OP_SMOOTH) && smooth_ok))) begin
            done_next                = 1'b1;
            result_next.out_of_range = is_access;
            result_next.read_value   = (cmd.opcode == OP_READ);
          end
        end
      end
      S_ACCESS: begin
        done_next = 1'b1;
        if (cur.opcode == OP_READ) begin
          result_next.read_value = ram_rdata[cur_col_idx];
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ROW_W'(cur.cell_row);
          ram_wdata = mod_row;
        end
      end
      S_LOAD_UP:  ram_raddr = ROW_W'(1);
      S_LOAD_MID: ram_raddr = ROW_W'(row_cnt + DIM_W'(1));
      S_LOAD_DN:  ram_raddr = '0;
      S_COLUMN:   ram_raddr = '0;
      S_WRITE: begin
        ram_we = 1'b1;
        if (!last_row) begin
          ram_raddr = ROW_W'(row_cnt + DIM_W'(2));
        end else if (last_pass) begin
          done_next               = 1'b1;
          result_next.passes_done = pass_count;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      done        <= 1'b0;
      row_cnt     <= '0;
      col_cnt     <= '0;
      pass_idx    <= '0;
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
      wall_limit  <= 4'd4;
      pass_count  <= 4'd5;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  grid_width  <= cfg_data;
          CFG_GRID_HEIGHT: grid_height <= cfg_data;
          CFG_WALL_LIMIT:  wall_limit  <= cfg_data[3:0];
          CFG_PASS_COUNT:  pass_count  <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR:  row_cnt <= row_cnt + DIM_W'(1);
        S_IDLE: begin
          if (accept) begin
            row_cnt  <= DIM_W'(1);
            pass_idx <= '0;
          end
        end
        S_LOAD_DN: col_cnt <= DIM_W'(1);
        S_COLUMN:  col_cnt <= col_cnt + DIM_W'(1);
        S_WRITE: begin
          // Advance to the next row, or wrap to row one for the next pass.
          if (last_row) begin
            row_cnt  <= DIM_W'(1);
            pass_idx <= pass_idx + 4'd1;
          end else begin
            row_cnt <= row_cnt + DIM_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers: command, row window, work row, result word.
  always_ff @(posedge clk) begin
    result <= result_next;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur <= cmd;
        end
      end
      S_LOAD_UP: up <= ram_rdata;
      S_LOAD_MID: begin
        mid    <= ram_rdata;
        newrow <= ram_rdata;
      end
      S_LOAD_DN: dn <= ram_rdata;
      S_COLUMN:  newrow[COL_W'(col_cnt)] <= new_bit;
      S_WRITE: begin
        // Slide the window down one row; old rows stay in the window, so
        // the new row can go back to its own RAM row.
        up     <= mid;
        mid    <= dn;
        newrow <= dn;
      end
      default: ;
    endcase
  end

  // In-range reads and writes raise done after passing through the access state.
  a_access_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && is_access && in_range) |=> ##1 done)
    else $error("in-range access did not answer in two cycles");

  // The neighbour unit only ever sees interior columns.
  a_column_interior: assert property (@(posedge clk) disable iff (rst)
    (state == S_COLUMN) |-> ((col_cnt >= DIM_W'(1)) &&
                             (DIM_W'(col_cnt + DIM_W'(2)) <= used_w)))
    else $error("column walk left the interior");

  // Only a smooth word reports passes, and never with an access flag.
  a_passes_only_smooth: assert property (@(posedge clk) disable iff (rst)
    (done && (cur.opcode != OP_SMOOTH)) |-> (result.passes_done == 4'd0))
    else $error("passes reported for a non-smooth word");

  a_flag_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.out_of_range && (result.passes_done != 4'd0)))
    else $error("range flag and pass count both set");

endmodule

`default_nettype wire
